FILE: sv/apta_pkg.sv
// ----------------------------------------------------------------------------
// apta_pkg
// Shared types and codes for the pulse template averager.
// ----------------------------------------------------------------------------
package apta_pkg;

    localparam logic OP_DIV  = 1'b0;
    localparam logic OP_SQRT = 1'b1;

    localparam logic CMD_SEED = 1'b0;
    localparam logic CMD_ACC  = 1'b1;

    localparam int XW    = 64;
    localparam int REM_W = 36;
    localparam int DEN_W = 24;
    localparam int CNT_W = 7;

    typedef struct packed {
        logic             start;
        logic             op;
        logic [CNT_W-1:0] count;
        logic [XW-1:0]    x;
        logic [DEN_W-1:0] den;
    } t_su_req;

    typedef struct packed {
        logic          done;
        logic [XW-1:0] q;
    } t_su_rsp;

endpackage

FILE: sv/apta_ram.sv
// ----------------------------------------------------------------------------
// apta_ram
// Generic single write port RAM with one registered read port.
// ----------------------------------------------------------------------------
module apta_ram #(
    parameter int W     = 64,
    parameter int DEPTH = 1024,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [W-1:0]  i_wdata,
    input  logic          i_re,
    input  logic [AW-1:0] i_raddr,
    output logic [W-1:0]  o_rdata
);

    logic [W-1:0] mem [DEPTH];
    logic [W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: sv/apta_divsqrt.sv
// ----------------------------------------------------------------------------
// apta_divsqrt
// Shared bit-serial unit: restoring divide (one quotient bit per cycle)
// or integer square root (one root bit per cycle) on one compare-subtract.
// ----------------------------------------------------------------------------
module apta_divsqrt (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  apta_pkg::t_su_req i_req,
    output apta_pkg::t_su_rsp o_rsp
);

    logic                          r_busy;
    logic                          r_done;
    logic [apta_pkg::CNT_W-1:0]    r_cnt;
    logic                          r_op;
    logic [apta_pkg::XW-1:0]       r_x;
    logic [apta_pkg::XW-1:0]       r_q;
    logic [apta_pkg::REM_W-1:0]    r_rem;
    logic [apta_pkg::DEN_W-1:0]    r_den;

    logic [apta_pkg::REM_W-1:0]    w_sh;
    logic [apta_pkg::REM_W-1:0]    w_trial;
    logic                          w_ge;

    always_comb begin
        if (r_op == apta_pkg::OP_DIV) begin
            w_sh    = {r_rem[apta_pkg::REM_W-2:0], r_x[apta_pkg::XW-1]};
            w_trial = apta_pkg::REM_W'(r_den);
        end else begin
            w_sh    = {r_rem[apta_pkg::REM_W-3:0], r_x[apta_pkg::XW-1 -: 2]};
            w_trial = apta_pkg::REM_W'({r_q[31:0], 2'b01});
        end
        w_ge = (w_sh >= w_trial);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
            end else if (r_busy && r_cnt == apta_pkg::CNT_W'(1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_cnt <= i_req.count;
            r_op  <= i_req.op;
            r_x   <= i_req.x;
            r_den <= i_req.den;
            r_q   <= '0;
            r_rem <= '0;
        end else if (r_busy) begin
            r_cnt <= r_cnt - apta_pkg::CNT_W'(1);
            r_rem <= w_ge ? (w_sh - w_trial) : w_sh;
            r_q   <= {r_q[apta_pkg::XW-2:0], w_ge};
            r_x   <= (r_op == apta_pkg::OP_DIV) ? (r_x << 1) : (r_x << 2);
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.q    = r_q;

endmodule

FILE: sv/aligned_pulse_template_averager_unit.sv
// ----------------------------------------------------------------------------
// aligned_pulse_template_averager_unit
// Pulse template kept as a per-bin running mean and sigma.
// ----------------------------------------------------------------------------
// Input items arrive on i_valid / o_stall, one result item per input item
// leaves on o_valid / i_stall. initial_sigma is written with i_cfg_we.
// A seed item writes its bin when that bin lies inside the template. An
// accumulate item is worked through a sequencer around one shared
// bit-serial divide / square root unit: correction divide (skipped when
// the scale factor is zero), mean divide, variance divide and square root
// (both skipped while the pulse count is zero), plus template reads,
// multiplies and sums; an item whose shifted bin misses the template
// writes nothing. The divide unit sets the rate; o_stall is high while an
// item is in work. A finished result sits in the output register while the
// next item is taken; if the receiver still stalls when the following
// result is ready, the sequencer holds until the register frees.
// Reset clears the pulse count, the latched pedestal and initial_sigma;
// the template bins are undefined until seeded.
// ----------------------------------------------------------------------------
module aligned_pulse_template_averager_unit #(
    parameter int NUM_BINS = 1024
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [23:0]        i_cfg_wdata,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic               i_command,
    input  logic [9:0]         i_pulse_bin,
    input  logic signed [24:0] i_sample_value,
    input  logic signed [24:0] i_pedestal_offset,
    input  logic [23:0]        i_scale_factor,
    input  logic signed [20:0] i_time_offset,
    input  logic               i_first_of_pulse,
    input  logic               i_last_of_pulse,
    output logic               o_valid,
    input  logic               i_stall,
    output logic [9:0]         o_bin_index,
    output logic               o_bin_written,
    output logic signed [31:0] o_bin_mean,
    output logic [31:0]        o_bin_sigma,
    output logic [15:0]        o_pulse_count
);

    localparam int AW = $clog2(NUM_BINS);
    localparam logic [16:0] NB = 17'(NUM_BINS);

    localparam logic [4:0] S_IDLE   = 5'd0;
    localparam logic [4:0] S_SEED   = 5'd1;
    localparam logic [4:0] S_PEDR   = 5'd2;
    localparam logic [4:0] S_PEDW   = 5'd3;
    localparam logic [4:0] S_TGT    = 5'd4;
    localparam logic [4:0] S_OLD    = 5'd5;
    localparam logic [4:0] S_CDIV   = 5'd6;
    localparam logic [4:0] S_MMUL   = 5'd7;
    localparam logic [4:0] S_MSTART = 5'd8;
    localparam logic [4:0] S_MDIV   = 5'd9;
    localparam logic [4:0] S_VSQ    = 5'd10;
    localparam logic [4:0] S_VPM    = 5'd11;
    localparam logic [4:0] S_VAM    = 5'd12;
    localparam logic [4:0] S_VACC   = 5'd13;
    localparam logic [4:0] S_VDIV   = 5'd14;
    localparam logic [4:0] S_SQRT   = 5'd15;
    localparam logic [4:0] S_WR     = 5'd16;
    localparam logic [4:0] S_OUT    = 5'd17;

    function automatic logic signed [31:0] sat32(input logic signed [51:0] v);
        logic signed [31:0] r;
        if (v > 52'sd2147483647) begin
            r = 32'sh7fffffff;
        end else if (v < -52'sd2147483648) begin
            r = 32'sh80000000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

    logic [4:0]  r_state, n_state;

    // control
    logic        r_ov;
    logic [15:0] r_cnt;
    logic signed [31:0] r_lped;
    logic [23:0] r_cfg;

    // item
    logic [9:0]  r_pbin;
    logic signed [24:0] r_samp;
    logic signed [24:0] r_poff;
    logic [23:0] r_scale;
    logic signed [20:0] r_toff;
    logic        r_first;
    logic        r_last;

    // work
    logic [AW-1:0]      r_t;
    logic [9:0]         r_idx;
    logic               r_wr;
    logic signed [31:0] r_old_m;
    logic [31:0]        r_old_s;
    logic signed [31:0] r_c;
    logic signed [48:0] r_prod;
    logic signed [31:0] r_nmean;
    logic [31:0]        r_res_sig;
    logic [63:0]        r_a;
    logic [63:0]        r_pm;
    logic               r_neg;
    logic [79:0]        r_am;

    // result
    logic [9:0]         r_o_idx;
    logic               r_o_wr;
    logic signed [31:0] r_o_mean;
    logic [31:0]        r_o_sig;
    logic [15:0]        r_o_cnt;

    apta_pkg::t_su_req  w_req;
    apta_pkg::t_su_rsp  w_rsp;

    logic               w_we, w_re;
    logic [AW-1:0]      w_raddr;
    logic [63:0]        w_rdata;

    // time shift
    logic [10:0]        w_pb1;
    logic signed [23:0] w_x;
    logic [15:0]        w_b1;
    logic [15:0]        w_t;
    logic               w_inr;
    logic [15:0]        w_pb16;
    logic               w_seed_inr;

    // correction
    logic signed [25:0] w_v;
    logic [25:0]        w_vm;
    logic [41:0]        w_cdiv;
    logic signed [51:0] w_cq;
    logic signed [51:0] w_qz;

    // mean
    logic [16:0]        w_den;
    logic signed [49:0] w_mn;
    logic [49:0]        w_mm;
    logic [49:0]        w_md;
    logic signed [51:0] w_mq;

    // variance
    logic signed [32:0] w_d1, w_d2;
    logic [32:0]        w_m1, w_m2;
    logic [63:0]        w_asat;
    logic [64:0]        w_sum;
    logic [63:0]        w_acc;

    apta_ram #(.W(64), .DEPTH(NUM_BINS), .AW(AW)) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (r_t),
        .i_wdata ({r_nmean, r_res_sig}),
        .i_re    (w_re),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    apta_divsqrt u_su (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_req),
        .o_rsp   (w_rsp)
    );

    always_comb begin
        w_pb1      = {1'b0, r_pbin} + 11'd1;
        w_x        = $signed({5'b0, w_pb1, 8'h80}) - 24'(r_toff);
        w_b1       = w_x[23:8];
        w_t        = w_b1 - 16'd1;
        w_inr      = !w_x[23] && (w_b1 != 16'd0) && ({1'b0, w_b1} <= NB);
        w_pb16     = {6'b0, r_pbin};
        w_seed_inr = ({7'b0, r_pbin} < NB);

        w_v    = 26'(r_samp) - 26'(r_poff);
        w_vm   = w_v[25] ? -w_v : w_v;
        w_cdiv = 42'({w_vm[24:0], 16'b0}) + 42'(r_scale[23:1]);
        w_cq   = w_v[25] ? -$signed({10'b0, w_rsp.q[41:0]}) : $signed({10'b0, w_rsp.q[41:0]});
        if (w_v[25]) begin
            w_qz = -52'sd2147483648;
        end else if (w_v != 26'sd0) begin
            w_qz = 52'sd2147483647;
        end else begin
            w_qz = 52'sd0;
        end

        w_den = {1'b0, r_cnt} + 17'd1;
        w_mn  = 50'(r_prod) + 50'(r_c);
        w_mm  = w_mn[49] ? 50'(-w_mn) : 50'(w_mn);
        w_md  = w_mm + 50'(w_den[16:1]);
        w_mq  = w_mn[49] ? -$signed({2'b0, w_rsp.q[49:0]}) : $signed({2'b0, w_rsp.q[49:0]});

        w_d1 = 33'(r_c) - 33'(r_old_m);
        w_d2 = 33'(r_c) - 33'(r_nmean);
        w_m1 = w_d1[32] ? 33'(-w_d1) : 33'(w_d1);
        w_m2 = w_d2[32] ? 33'(-w_d2) : 33'(w_d2);

        w_asat = (r_am[79:64] != 16'd0) ? {64{1'b1}} : r_am[63:0];
        w_sum  = {1'b0, w_asat} + {1'b0, r_pm};
        if (r_neg) begin
            w_acc = (w_asat > r_pm) ? (w_asat - r_pm) : 64'd0;
        end else begin
            w_acc = w_sum[64] ? {64{1'b1}} : w_sum[63:0];
        end
    end

    always_comb begin
        n_state   = r_state;
        w_req     = '0;
        w_we      = 1'b0;
        w_re      = 1'b0;
        w_raddr   = w_t[AW-1:0];
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_state = (i_command == apta_pkg::CMD_SEED) ? S_SEED : S_PEDR;
                end
            end
            S_SEED: n_state = S_WR;
            S_PEDR: begin
                if (r_first) begin
                    w_re    = 1'b1;
                    w_raddr = '0;
                    n_state = S_PEDW;
                end else begin
                    n_state = S_TGT;
                end
            end
            S_PEDW: n_state = S_TGT;
            S_TGT: begin
                if (w_inr) begin
                    w_re    = 1'b1;
                    n_state = S_OLD;
                end else begin
                    n_state = S_WR;
                end
            end
            S_OLD: begin
                if (r_scale == 24'd0) begin
                    n_state = S_MMUL;
                end else begin
                    w_req.start = 1'b1;
                    w_req.op    = apta_pkg::OP_DIV;
                    w_req.count = apta_pkg::CNT_W'(42);
                    w_req.x     = {w_cdiv, 22'b0};
                    w_req.den   = r_scale;
                    n_state     = S_CDIV;
                end
            end
            S_CDIV: begin
                if (w_rsp.done) begin
                    n_state = S_MMUL;
                end
            end
            S_MMUL: n_state = S_MSTART;
            S_MSTART: begin
                w_req.start = 1'b1;
                w_req.op    = apta_pkg::OP_DIV;
                w_req.count = apta_pkg::CNT_W'(50);
                w_req.x     = {w_md, 14'b0};
                w_req.den   = apta_pkg::DEN_W'(w_den);
                n_state     = S_MDIV;
            end
            S_MDIV: begin
                if (w_rsp.done) begin
                    n_state = (r_cnt == 16'd0) ? S_WR : S_VSQ;
                end
            end
            S_VSQ: n_state = S_VPM;
            S_VPM: n_state = S_VAM;
            S_VAM: n_state = S_VACC;
            S_VACC: begin
                w_req.start = 1'b1;
                w_req.op    = apta_pkg::OP_DIV;
                w_req.count = apta_pkg::CNT_W'(64);
                w_req.x     = w_acc;
                w_req.den   = apta_pkg::DEN_W'(r_cnt);
                n_state     = S_VDIV;
            end
            S_VDIV: begin
                if (w_rsp.done) begin
                    w_req.start = 1'b1;
                    w_req.op    = apta_pkg::OP_SQRT;
                    w_req.count = apta_pkg::CNT_W'(32);
                    w_req.x     = w_rsp.q;
                    n_state     = S_SQRT;
                end
            end
            S_SQRT: begin
                if (w_rsp.done) begin
                    n_state = S_WR;
                end
            end
            S_WR: begin
                w_we    = r_wr;
                n_state = S_OUT;
            end
            S_OUT: begin
                if (!r_ov || !i_stall) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ov    <= 1'b0;
            r_cnt   <= '0;
            r_lped  <= '0;
            r_cfg   <= '0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                r_cfg <= i_cfg_wdata;
            end
            if (r_state == S_PEDW) begin
                r_lped <= w_rdata[63:32];
            end
            if (r_state == S_WR && r_last && r_cnt != 16'hffff) begin
                r_cnt <= r_cnt + 16'd1;
            end
            if (r_state == S_OUT && (!r_ov || !i_stall)) begin
                r_ov <= 1'b1;
            end else if (!i_stall) begin
                r_ov <= 1'b0;
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && i_valid) begin
            r_pbin  <= i_pulse_bin;
            r_samp  <= i_sample_value;
            r_poff  <= i_pedestal_offset;
            r_scale <= i_scale_factor;
            r_toff  <= i_time_offset;
            r_first <= i_first_of_pulse;
            r_last  <= i_last_of_pulse;
        end
        case (r_state)
            S_SEED: begin
                r_t       <= w_pb16[AW-1:0];
                r_idx     <= r_pbin;
                r_wr      <= w_seed_inr;
                r_nmean   <= w_seed_inr ? 32'(r_samp) : 32'sd0;
                r_res_sig <= w_seed_inr ? {8'b0, r_cfg} : 32'd0;
            end
            S_TGT: begin
                r_t       <= w_t[AW-1:0];
                r_idx     <= w_inr ? w_t[9:0] : 10'd0;
                r_wr      <= w_inr;
                r_nmean   <= '0;
                r_res_sig <= '0;
            end
            S_OLD: begin
                r_old_m <= w_rdata[63:32];
                r_old_s <= w_rdata[31:0];
                r_c     <= sat32(w_qz + 52'(r_lped));
            end
            S_CDIV: begin
                if (w_rsp.done) begin
                    r_c <= sat32(w_cq + 52'(r_lped));
                end
            end
            S_MMUL: r_prod <= $signed({1'b0, r_cnt}) * r_old_m;
            S_MDIV: begin
                if (w_rsp.done) begin
                    r_nmean   <= sat32(w_mq);
                    r_res_sig <= '0;
                end
            end
            S_VSQ: r_a <= r_old_s * r_old_s;
            S_VPM: begin
                r_pm  <= w_m1[31:0] * w_m2[31:0];
                r_neg <= w_d1[32] ^ w_d2[32];
            end
            S_VAM: r_am <= r_a * (r_cnt - 16'd1);
            S_SQRT: begin
                if (w_rsp.done) begin
                    r_res_sig <= w_rsp.q[31:0];
                end
            end
            S_OUT: begin
                if (!r_ov || !i_stall) begin
                    r_o_idx  <= r_idx;
                    r_o_wr   <= r_wr;
                    r_o_mean <= r_nmean;
                    r_o_sig  <= r_res_sig;
                    r_o_cnt  <= r_cnt;
                end
            end
            default: begin
            end
        endcase
    end

    assign o_stall       = (r_state != S_IDLE);
    assign o_valid       = r_ov;
    assign o_bin_index   = r_o_idx;
    assign o_bin_written = r_o_wr;
    assign o_bin_mean    = r_o_mean;
    assign o_bin_sigma   = r_o_sig;
    assign o_pulse_count = r_o_cnt;

endmodule
